/* rtl/core/stb_pkg.sv */
// Shared types and constants for the software timer bank.
`default_nettype none

package stb_pkg;

  localparam int FUNC_W   = 3;
  localparam int IDX_W    = 3;
  localparam int COUNT_W  = 32;
  localparam int STATUS_W = 2;

  // Operation codes; codes 5 to 7 are ignored
  typedef enum logic [FUNC_W-1:0] {
    OP_TICK  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_READ  = 3'd3,
    OP_VALUE = 3'd4
  } op_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_ACK         = 2'd0,
    STAT_EXPIRED     = 2'd1,
    STAT_WAITING     = 2'd2,
    STAT_NOT_STARTED = 2'd3
  } status_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_FLUSH,
    ST_VREAD,
    ST_VWAIT,
    ST_RESULT
  } ctrl_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;    // latch the input beat, clear result and sweep counter
    logic exec_op;    // apply start / stop / read status to the addressed timer
    logic sweep_rd;   // read the count of the next timer in the tick sweep
    logic value_rd;   // read the count of the addressed timer
    logic value_lat;  // latch the read count into the result
    logic out_load;   // move the result into the output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic sweep_last; // sweep counter points at the last timer
    logic out_free;   // output register can take a result this cycle
  } sts_t;

endpackage

`default_nettype wire

/* rtl/core/stb_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none

module stb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/stb_ctrl.sv */
// Controller state machine for the software timer bank.
`default_nettype none

module stb_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic [stb_pkg::FUNC_W-1:0] in_func,
  output logic                            in_stall,
  input  wire stb_pkg::sts_t              sts,
  output stb_pkg::cmd_t                   cmd
);

  stb_pkg::ctrl_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      stb_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (stb_pkg::op_t'(in_func))
            stb_pkg::OP_TICK:  state_nxt = stb_pkg::ST_SWEEP;
            stb_pkg::OP_VALUE: state_nxt = stb_pkg::ST_VREAD;
            default:           state_nxt = stb_pkg::ST_EXEC;
          endcase
        end
      end
      stb_pkg::ST_EXEC: begin
        cmd.exec_op = 1'b1;
        state_nxt   = stb_pkg::ST_RESULT;
      end
      // one timer read per cycle; write-back follows in the next cycle
      stb_pkg::ST_SWEEP: begin
        cmd.sweep_rd = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = stb_pkg::ST_FLUSH;
        end
      end
      stb_pkg::ST_FLUSH: begin
        state_nxt = stb_pkg::ST_RESULT;
      end
      stb_pkg::ST_VREAD: begin
        cmd.value_rd = 1'b1;
        state_nxt    = stb_pkg::ST_VWAIT;
      end
      stb_pkg::ST_VWAIT: begin
        cmd.value_lat = 1'b1;
        state_nxt     = stb_pkg::ST_RESULT;
      end
      stb_pkg::ST_RESULT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = stb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = stb_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/stb_datapath.sv */
// Datapath: timer flags, count memory, tick sweep and output register.
`default_nettype none

module stb_datapath #(
  parameter int TIMER_COUNT = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [stb_pkg::FUNC_W-1:0]   in_func,
  input  wire logic [stb_pkg::IDX_W-1:0]    in_timer_index,
  input  wire logic [stb_pkg::COUNT_W-1:0]  in_load_count,
  input  wire stb_pkg::cmd_t                cmd,
  output stb_pkg::sts_t                     sts,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [stb_pkg::STATUS_W-1:0]      out_status,
  output logic [stb_pkg::COUNT_W-1:0]       out_remaining
);

  localparam int AW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

  // Latched input beat
  stb_pkg::op_t                 op_r;
  logic [stb_pkg::IDX_W-1:0]    idx_r;
  logic [stb_pkg::COUNT_W-1:0]  load_r;

  // Per-timer flags; written_r marks a count entry that holds real data
  logic [TIMER_COUNT-1:0] running_r;
  logic [TIMER_COUNT-1:0] expired_r;
  logic [TIMER_COUNT-1:0] written_r;

  // Sweep counter and the pending write-back stage
  logic [AW-1:0] cnt_r;
  logic          pend_r;
  logic [AW-1:0] pend_addr_r;

  // Held result and output register
  stb_pkg::status_t             res_status_r;
  logic [stb_pkg::COUNT_W-1:0]  res_rem_r;
  logic                         out_valid_r;
  stb_pkg::status_t             out_status_r;
  logic [stb_pkg::COUNT_W-1:0]  out_rem_r;

  logic                         idx_ok;
  logic [AW-1:0]                idx_addr;
  logic [stb_pkg::COUNT_W-1:0]  rd_data;
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [stb_pkg::COUNT_W-1:0]  ram_wdata;
  logic                         ram_re;
  logic [AW-1:0]                ram_raddr;
  logic                         proc_hit;
  logic [stb_pkg::COUNT_W-1:0]  proc_cnt;
  logic                         proc_zero;
  stb_pkg::status_t             exec_status;

  assign idx_ok   = (32'(idx_r) < TIMER_COUNT);
  assign idx_addr = AW'(idx_r);

  // Tick step for the timer whose count just came out of the memory
  assign proc_hit  = pend_r && running_r[pend_addr_r] && !expired_r[pend_addr_r];
  assign proc_cnt  = written_r[pend_addr_r] ? rd_data : '0;
  assign proc_zero = (proc_cnt == '0);

  // Memory port muxing; start and the sweep never overlap
  assign ram_we    = (proc_hit && !proc_zero) ||
                     (cmd.exec_op && (op_r == stb_pkg::OP_START) && idx_ok);
  assign ram_waddr = cmd.exec_op ? idx_addr : pend_addr_r;
  assign ram_wdata = cmd.exec_op ? load_r : (proc_cnt - 32'd1);
  assign ram_re    = cmd.sweep_rd || cmd.value_rd;
  assign ram_raddr = cmd.sweep_rd ? cnt_r : idx_addr;

  stb_ram #(
    .WIDTH (stb_pkg::COUNT_W),
    .DEPTH (TIMER_COUNT)
  ) u_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // Status answer for a read-status operation
  always_comb begin
    exec_status = stb_pkg::STAT_ACK;
    if (op_r == stb_pkg::OP_READ) begin
      if (!idx_ok || !running_r[idx_addr]) begin
        exec_status = stb_pkg::STAT_NOT_STARTED;
      end else if (expired_r[idx_addr]) begin
        exec_status = stb_pkg::STAT_EXPIRED;
      end else begin
        exec_status = stb_pkg::STAT_WAITING;
      end
    end
  end

  // Input beat capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= stb_pkg::op_t'(in_func);
      idx_r  <= in_timer_index;
      load_r <= in_load_count;
    end
  end

  // Timer flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= '0;
      expired_r <= '0;
      written_r <= '0;
    end else begin
      if (proc_hit) begin
        if (proc_zero) begin
          expired_r[pend_addr_r] <= 1'b1;
        end else begin
          written_r[pend_addr_r] <= 1'b1;
        end
      end
      if (cmd.exec_op && idx_ok) begin
        case (op_r)
          stb_pkg::OP_START: begin
            running_r[idx_addr] <= 1'b1;
            expired_r[idx_addr] <= 1'b0;
            written_r[idx_addr] <= 1'b1;
          end
          stb_pkg::OP_STOP: begin
            running_r[idx_addr] <= 1'b0;
            expired_r[idx_addr] <= 1'b0;
          end
          stb_pkg::OP_READ: begin
            if (running_r[idx_addr] && expired_r[idx_addr]) begin
              running_r[idx_addr] <= 1'b0;
              expired_r[idx_addr] <= 1'b0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Sweep counter and write-back stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      pend_r <= cmd.sweep_rd;
      if (cmd.capture) begin
        cnt_r <= '0;
      end else if (cmd.sweep_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep_rd) begin
      pend_addr_r <= cnt_r;
    end
  end

  assign sts.sweep_last = (cnt_r == AW'(TIMER_COUNT - 1));

  // Held result
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_status_r <= stb_pkg::STAT_ACK;
      res_rem_r    <= '0;
    end else begin
      if (cmd.exec_op) begin
        res_status_r <= exec_status;
      end
      if (cmd.value_lat && idx_ok && written_r[idx_addr]) begin
        res_rem_r <= rd_data;
      end
    end
  end

  // Output register
  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_rem_r    <= res_rem_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_remaining = out_rem_r;

endmodule

`default_nettype wire

/* rtl/core/software_timer_bank_top.sv */
// Top level of the software timer bank: controller plus datapath.
// Start, stop, read status and unused codes pass through the exec state; read
// remaining reads and latches the count; tick sweeps every timer and flushes.
// One beat at a time: a new beat is taken only after the last result is loaded
// into the output register. A tick sweeps the count memory one timer per cycle.
// Reset (rst_n low, synchronous) stops and clears every timer at once.
`default_nettype none

module software_timer_bank_top #(
  parameter int TIMER_COUNT = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [stb_pkg::FUNC_W-1:0]    in_func,
  input  wire logic [stb_pkg::IDX_W-1:0]     in_timer_index,
  input  wire logic [stb_pkg::COUNT_W-1:0]   in_load_count,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [stb_pkg::STATUS_W-1:0]       out_status,
  output logic [stb_pkg::COUNT_W-1:0]        out_remaining
);

  stb_pkg::cmd_t cmd;
  stb_pkg::sts_t sts;

  stb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  stb_datapath #(
    .TIMER_COUNT (TIMER_COUNT)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_func        (in_func),
    .in_timer_index (in_timer_index),
    .in_load_count  (in_load_count),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_remaining  (out_remaining)
  );

endmodule

`default_nettype wire

/* test/software_timer_bank_checker.sv */
`timescale 1ns / 100ps
// Checker for the software timer bank: tracks timer state, predicts and compares result beats.
module software_timer_bank_checker #(
  parameter int TIMER_COUNT = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [stb_pkg::FUNC_W-1:0]   in_func,
  input  logic [stb_pkg::IDX_W-1:0]    in_timer_index,
  input  logic [stb_pkg::COUNT_W-1:0]  in_load_count,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [stb_pkg::STATUS_W-1:0] out_status,
  input  logic [stb_pkg::COUNT_W-1:0]  out_remaining,
  output int                           mismatches,
  output int                           results_owed
);
  import stb_pkg::*;

  typedef struct {
    status_t              status;
    logic [COUNT_W-1:0]   remaining;
  } timer_result_t;

  // Shadow copy of the timer bank
  logic               timer_running [TIMER_COUNT];
  logic               timer_expired [TIMER_COUNT];
  logic [COUNT_W-1:0] timer_count   [TIMER_COUNT];

  timer_result_t expected_results [$];
  int            mismatch_total = 0;
  int            owed_count = 0;
  int            result_num = 0;

  assign mismatches   = mismatch_total;
  assign results_owed = owed_count;

  task automatic report_mismatch(input string msg);
    $display("[%0t] result %0d mismatch: %s", $time, result_num, msg);
    mismatch_total++;
  endtask

  // Apply one operation to the shadow bank and return the answer it earns
  function automatic timer_result_t predict_timer_op(input logic [FUNC_W-1:0] func,
                                                     input logic [IDX_W-1:0]  idx,
                                                     input logic [COUNT_W-1:0] load);
    timer_result_t res;
    logic          in_bank;
    int            t;
    in_bank       = idx < TIMER_COUNT;
    t             = in_bank ? int'(idx) : 0;
    res.status    = STAT_ACK;
    res.remaining = '0;
    case (op_t'(func))
      OP_TICK: begin
        for (int i = 0; i < TIMER_COUNT; i++) begin
          if (timer_running[i] && !timer_expired[i]) begin
            if (timer_count[i] != '0) timer_count[i] = timer_count[i] - 1'b1;
            else timer_expired[i] = 1'b1;
          end
        end
      end
      OP_START: begin
        if (in_bank) begin
          timer_count[t]   = load;
          timer_expired[t] = 1'b0;
          timer_running[t] = 1'b1;
        end
      end
      OP_STOP: begin
        if (in_bank) begin
          timer_running[t] = 1'b0;
          timer_expired[t] = 1'b0;
        end
      end
      OP_READ: begin
        if (!in_bank || !timer_running[t]) begin
          res.status = STAT_NOT_STARTED;
        end else if (timer_expired[t]) begin
          // an expired answer also stops the timer
          timer_running[t] = 1'b0;
          timer_expired[t] = 1'b0;
          res.status       = STAT_EXPIRED;
        end else begin
          res.status = STAT_WAITING;
        end
      end
      OP_VALUE: begin
        if (in_bank) res.remaining = timer_count[t];
      end
      default: ;
    endcase
    return res;
  endfunction

  // Compare result beats first, then record the prediction for an accepted input beat
  always @(posedge clk) begin
    timer_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < TIMER_COUNT; i++) begin
        timer_running[i] = 1'b0;
        timer_expired[i] = 1'b0;
        timer_count[i]   = '0;
      end
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected beat, status %0d remaining %0h",
                                    out_status, out_remaining));
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
          if (out_remaining !== want.remaining)
            report_mismatch($sformatf("remaining %0h, want %0h", out_remaining,
                                      want.remaining));
        end
        result_num++;
      end
      if (in_valid && !in_stall)
        expected_results.push_back(predict_timer_op(in_func, in_timer_index, in_load_count));
    end
    owed_count = expected_results.size();
  end

endmodule

/* test/software_timer_bank_top_tb.sv */
`timescale 1ns / 100ps
// Testbench top for the software timer bank: stimulus, idling phases and the verdict.
module software_timer_bank_top_tb;
  import stb_pkg::*;

  localparam int TIMER_COUNT   = 8;
  localparam int RANDOM_BEATS  = 600;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = TIMER_COUNT + 8;
  localparam int HOLD_CYCLES   = 300;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [FUNC_W-1:0]   in_func = OP_TICK;
  logic [IDX_W-1:0]    in_timer_index = '0;
  logic [COUNT_W-1:0]  in_load_count = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0]  out_remaining;

  int mismatches;
  int results_owed;
  int cycle_num = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_target = 0;  // raised by the stimulus process
  int hold_count = 0;   // advanced by the receiver process

  software_timer_bank_top #(.TIMER_COUNT(TIMER_COUNT)) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_timer_index (in_timer_index),
    .in_load_count  (in_load_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_remaining  (out_remaining)
  );

  software_timer_bank_checker #(.TIMER_COUNT(TIMER_COUNT)) checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_timer_index (in_timer_index),
    .in_load_count  (in_load_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_remaining  (out_remaining),
    .mismatches     (mismatches),
    .results_owed   (results_owed)
  );

  always #4 clk = ~clk;

  // Timeout
  always @(posedge clk) begin
    cycle_num <= cycle_num + 1;
    if (cycle_num == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side: long hold-off when requested, else random stalls
  always @(negedge clk) begin
    if (hold_count < hold_target) begin
      out_stall  <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Offer one beat, with random idle cycles ahead of it, and wait until it is taken
  task automatic drive_beat(input logic [FUNC_W-1:0] func, input logic [IDX_W-1:0] idx,
                            input logic [COUNT_W-1:0] load);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= func;
    in_timer_index <= idx;
    in_load_count  <= load;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop sending until every predicted result has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
  endtask

  // Random beat, mostly small counts so timers run out and expire
  task automatic random_beat(output bit counted);
    logic [FUNC_W-1:0]  func;
    logic [COUNT_W-1:0] load;
    int unsigned        pick;
    pick = $urandom_range(0, 99);
    if (pick < 35)      func = OP_TICK;
    else if (pick < 50) func = OP_START;
    else if (pick < 57) func = OP_STOP;
    else if (pick < 77) func = OP_READ;
    else if (pick < 95) func = OP_VALUE;
    else                func = FUNC_W'($urandom_range(int'(OP_VALUE) + 1, (1 << FUNC_W) - 1));
    pick = $urandom_range(0, 9);
    if (pick < 7)      load = $urandom_range(0, 12);
    else if (pick < 9) load = $urandom();
    else               load = '1 - $urandom_range(0, 3);
    drive_beat(func, IDX_W'($urandom_range(0, (1 << IDX_W) - 1)), load);
    counted = func <= OP_VALUE;
  endtask

  initial begin
    int useful;
    bit counted;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, every operation, expiry and restart cases
    drive_beat(OP_READ, 3'd0, '0);              // never started
    drive_beat(OP_VALUE, 3'd7, '1);             // count reads zero after reset
    drive_beat(OP_START, 3'd0, '0);             // zero count expires on next tick
    drive_beat(OP_READ, 3'd0, '0);
    drive_beat(OP_START, 3'd7, '1);
    drive_beat(OP_TICK, 3'd3, '1);
    drive_beat(OP_READ, 3'd0, '0);              // expired, and now stopped
    drive_beat(OP_READ, 3'd0, '0);
    drive_beat(OP_VALUE, 3'd7, '0);
    drive_beat(OP_STOP, 3'd7, '0);
    drive_beat(OP_TICK, 3'd0, '0);              // stopped timer holds its count
    drive_beat(OP_VALUE, 3'd7, '0);
    drive_beat(OP_READ, 3'd7, '0);
    drive_beat(OP_START, 3'd3, 32'd2);
    drive_beat(OP_TICK, 3'd7, 32'd5);
    drive_beat(OP_TICK, 3'd0, 32'd0);
    drive_beat(OP_READ, 3'd3, '0);              // at zero but still waiting
    drive_beat(OP_TICK, 3'd0, 32'd0);
    drive_beat(OP_TICK, 3'd0, 32'd0);           // expired timer stays put
    drive_beat(OP_VALUE, 3'd3, '0);             // count reported whatever the flags
    drive_beat(OP_START, 3'd3, 32'd1);          // restart clears expired
    drive_beat(OP_READ, 3'd3, '0);
    drive_beat(3'd5, 3'd7, '1);
    drive_beat(3'd6, 3'd0, '0);
    drive_beat(3'd7, 3'd5, 32'h5555_AAAA);
    drain_results();

    // Random phases with different idling; the first one also fills the block up
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_target = hold_target + HOLD_CYCLES; end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      useful = 0;
      while (useful < RANDOM_BEATS / 4) begin
        random_beat(counted);
        if (counted) useful++;
      end
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && results_owed == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
